// ----- rtl/kst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the keyed snapshot table.
// No dependencies; imported by kst_table and keyed_snapshot_table_ttl.
package kst_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned EXPIRY_W = 16;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd2000;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_CONSUME = 1'b1
  } kst_op_t;

  typedef struct packed {
    kst_op_t              opcode;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic [TIME_W-1:0]    now_ms;
  } kst_req_t;

  typedef struct packed {
    logic                 matched;
    logic [VALUE_W-1:0]   result_value;
  } kst_rsp_t;

endpackage

// ----- rtl/kst_table.sv -----
`timescale 1ns / 1ps
// Fully associative snapshot store: parallel key compare, round-robin
// replacement, consume with expiry check. Depends on kst_pkg.
module kst_table import kst_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  kst_req_t            req,
  input  logic [EXPIRY_W-1:0] expiry_ms,
  output kst_rsp_t            rsp
);

  localparam int IW = $clog2(ENTRIES);

  logic [KEY_W-1:0]   entry_key   [ENTRIES];
  logic [VALUE_W-1:0] entry_value [ENTRIES];
  logic [TIME_W-1:0]  entry_time  [ENTRIES];
  logic [IW-1:0]      cursor;
  logic [IW-1:0]      cursor_next;

  logic [ENTRIES-1:0] hit;
  logic               any_hit;
  logic               key_live;
  logic [VALUE_W-1:0] got_value;
  logic [TIME_W-1:0]  got_time;
  logic [TIME_W-1:0]  age;
  logic               fresh;

  assign key_live = (req.key != '0);

  always_comb begin
    got_value = '0;
    got_time  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i]    = key_live && (entry_key[i] == req.key);
      got_value = got_value | (hit[i] ? entry_value[i] : '0);
      got_time  = got_time  | (hit[i] ? entry_time[i]  : '0);
    end
  end

  assign any_hit = |hit;
  assign age     = req.now_ms - got_time;
  assign fresh   = (age < {{(TIME_W-EXPIRY_W){1'b0}}, expiry_ms});

  always_comb begin
    rsp.matched      = any_hit;
    rsp.result_value = '0;
    if (req.opcode == OP_CONSUME && any_hit && got_value != '0 && fresh) begin
      rsp.result_value = got_value;
    end
  end

  always_comb begin
    if (cursor == IW'(ENTRIES - 1)) begin
      cursor_next = '0;
    end else begin
      cursor_next = cursor + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_key[i] <= '0;
      end
    end else if (fire && key_live) begin
      if (req.opcode == OP_STORE) begin
        if (!any_hit) begin
          entry_key[cursor] <= req.key;
          cursor            <= cursor_next;
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit[i]) begin
            entry_key[i] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && key_live) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (req.opcode == OP_STORE) begin
          if (hit[i] || (!any_hit && cursor == IW'(i))) begin
            entry_value[i] <= req.value;
            entry_time[i]  <= req.now_ms;
          end
        end else if (hit[i]) begin
          entry_value[i] <= '0;
          entry_time[i]  <= '0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    fire |-> $onehot0(hit))
    else $error("more than one entry holds the same key");

  a_zero_key_keeps_cursor: assert property (@(posedge clk) disable iff (rst)
    fire && !key_live |=> $stable(cursor))
    else $error("empty key moved the replacement cursor");

  a_update_keeps_cursor: assert property (@(posedge clk) disable iff (rst)
    fire && req.opcode == OP_STORE && any_hit |=> $stable(cursor))
    else $error("store to a present key moved the replacement cursor");
`endif

endmodule

// ----- rtl/keyed_snapshot_table_ttl.sv -----
`timescale 1ns / 1ps
// Keyed snapshot table with expiry: top level with input stage, table and
// result register. Depends on kst_pkg and kst_table.
//
// Usage:
//   req channel (req_valid, req_stall, req): one beat per store or consume.
//   rsp channel (rsp_valid, rsp_stall, rsp): exactly one beat per req beat,
//     in order: matched, and the live byte for a consume (else zero).
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes expiry_ms; always
//     ready. Write it only while no request is in flight.
// Pipeline: input stage, then table, then result register holding the rsp
//   beat. Throughput: one beat per cycle while no stall holds the result,
//   set by the parallel compare and update of all ENTRIES registered entries.
// Reset (rst, synchronous): all entries empty, replacement cursor at slot 0,
//   expiry_ms 2000, both pipeline stages empty.
// Stall: while rsp_stall holds a waiting result, the input stage holds one
//   more beat, then req_stall rises; no beat is lost or repeated.
module keyed_snapshot_table_ttl import kst_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  kst_req_t            req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output kst_rsp_t            rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [EXPIRY_W-1:0] cfg_data
);

  logic                s1_valid;
  kst_req_t            s1_req;
  logic                s1_go;
  logic                fire;
  logic [EXPIRY_W-1:0] expiry_ms;
  kst_rsp_t            table_rsp;

  assign s1_go     = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && s1_go;
  assign req_stall = s1_valid && !s1_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_ms <= EXPIRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expiry_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req <= req;
    end
  end

  kst_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (s1_req),
    .expiry_ms (expiry_ms),
    .rsp       (table_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= table_rsp;
    end
  end

`ifndef ASSERT_OFF
  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed beat produced no result");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_req))
    else $error("input stage lost or changed a waiting beat");

  a_zero_key_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && s1_req.key == '0 |=> !rsp.matched && rsp.result_value == '0)
    else $error("empty key reported a match or value");

  a_store_no_value: assert property (@(posedge clk) disable iff (rst)
    fire && s1_req.opcode == OP_STORE |=> rsp.result_value == '0)
    else $error("store returned a nonzero value");
`endif

endmodule
